@@ rtl/core/pdm_pkg.sv @@
`timescale 1ns / 1ps

package pdm_pkg;

    // Default sizing
    localparam int MAX_INPUT_CHANNELS_DEF = 8;
    localparam int MAX_BLOCK_FRAMES_DEF   = 8192;
    localparam int COUNT_HW_MAX           = 32767;
    localparam int QUEUE_DEPTH            = 4;

    // Fixed field widths
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int SAMPLE_W = 32;
    localparam int VALUE_W  = 17;
    localparam int LEVEL_W  = 36;
    localparam int MEAN_W   = 33;

    // Q2.15 limits
    localparam int Q_MAX_I = 65535;
    localparam int Q_MIN_I = -65536;

    // Sample format codes
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;

    // Output channel codes for mono and stereo
    localparam logic [1:0] OUT_MONO   = 2'd1;
    localparam logic [1:0] OUT_STEREO = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_FORMAT    = 2'd0;
    localparam logic [1:0] REG_INPUT_CH  = 2'd1;
    localparam logic [1:0] REG_OUTPUT_CH = 2'd2;

    localparam logic [3:0] INPUT_CH_RESET = 4'd2;

    // Configuration register set
    typedef struct packed {
        logic [1:0] sample_format;
        logic [3:0] input_channels;
        logic [1:0] output_channels;
    } cfg_t;

    // Control part of one queued frame record
    typedef struct packed {
        logic       frame_done;
        logic       last_in_block;
        logic       mono;
        logic [3:0] chans;
    } rec_ctl_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV_L,
        BK_WAIT_L,
        BK_DIV_R,
        BK_WAIT_R,
        BK_FORM,
        BK_SQ_A,
        BK_ACC_A,
        BK_SQ_B,
        BK_ACC_B,
        BK_END,
        BK_DIV_E,
        BK_WAIT_E,
        BK_LEVEL,
        BK_EMIT
    } back_state_t;

    localparam int REC_CTL_W = $bits(rec_ctl_t);

    // Width of a signed frame sum for the given channel limit
    function automatic int sum_width(input int max_ch);
        return 18 + $clog2((max_ch + 1) / 2);
    endfunction

    // Largest number of values counted per block
    function automatic int block_cap(input int frames);
        return (2 * frames > COUNT_HW_MAX) ? COUNT_HW_MAX : 2 * frames;
    endfunction

    function automatic int count_width(input int frames);
        return $clog2(block_cap(frames) + 1);
    endfunction

    function automatic int energy_width(input int frames);
        return 32 + count_width(frames);
    endfunction

endpackage

@@ rtl/core/pdm_front.sv @@
`timescale 1ns / 1ps

module pdm_front #(
    parameter int MAX_INPUT_CHANNELS = pdm_pkg::MAX_INPUT_CHANNELS_DEF,
    parameter int SUM_W              = pdm_pkg::sum_width(pdm_pkg::MAX_INPUT_CHANNELS_DEF)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pdm_pkg::cfg_t               cfg,
    input  logic [pdm_pkg::SAMPLE_W-1:0] sample_word,
    input  logic                        last_in_block,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic                        q_full,
    output logic                        q_push,
    output pdm_pkg::rec_ctl_t           q_ctl,
    output logic signed [SUM_W-1:0]     q_left,
    output logic signed [SUM_W-1:0]     q_right
);
    import pdm_pkg::*;

    logic [3:0]              pos_reg, pos_next;
    logic signed [SUM_W-1:0] left_reg, left_next;
    logic signed [SUM_W-1:0] right_reg, right_next;

    logic [3:0]              chans;
    logic [3:0]              pos_inc;
    logic                    frame_done;
    logic                    accept;
    logic signed [VALUE_W-1:0] dec;
    logic signed [SUM_W-1:0] dec_ext;

    logic                    f_neg;
    logic [7:0]              f_exp;
    logic [22:0]             f_frac;
    logic [7:0]              f_sh8;
    logic [4:0]              f_sh;
    logic [24:0]             f_rnd;
    logic [24:0]             f_sum;
    logic [24:0]             f_mag;
    logic signed [VALUE_W-1:0] f_val;
    logic signed [VALUE_W-1:0] f_sat;

    localparam logic signed [VALUE_W-1:0] V_MAX = VALUE_W'(Q_MAX_I);
    localparam logic signed [VALUE_W-1:0] V_MIN = VALUE_W'(Q_MIN_I);

    // Clamp the channel count into the supported range
    always_comb
    begin
        if (cfg.input_channels == 4'd0)
        begin
            chans = 4'd1;
        end
        else if (int'(cfg.input_channels) > MAX_INPUT_CHANNELS)
        begin
            chans = 4'(MAX_INPUT_CHANNELS);
        end
        else
        begin
            chans = cfg.input_channels;
        end
    end

    // Round the float32 sample to Q2.15, ties away from zero
    always_comb
    begin
        f_neg  = sample_word[31];
        f_exp  = sample_word[30:23];
        f_frac = sample_word[22:0];
        f_sh8  = 8'd135 - f_exp;
        f_sh   = f_sh8[4:0];
        f_rnd  = 25'd1 << (f_sh - 5'd1);
        f_sum  = {2'b01, f_frac} + f_rnd;
        f_mag  = f_sum >> f_sh;
        f_sat  = f_neg ? V_MIN : V_MAX;
        if (f_exp == 8'hFF)
        begin
            f_val = (f_frac != 23'd0) ? '0 : f_sat;
        end
        else if (f_exp == 8'd0)
        begin
            f_val = '0;
        end
        else if (f_exp >= 8'd135)
        begin
            f_val = f_sat;
        end
        else if (f_sh8 >= 8'd25)
        begin
            f_val = '0;
        end
        else if (f_neg)
        begin
            f_val = (f_mag >= 25'd65536) ? V_MIN : (VALUE_W'(0) - {1'b0, f_mag[15:0]});
        end
        else
        begin
            f_val = (f_mag > 25'd65535) ? V_MAX : {1'b0, f_mag[15:0]};
        end
    end

    // Select the decoder by format
    always_comb
    begin
        case (cfg.sample_format)
            FMT_U8:  dec = {~sample_word[7], ~sample_word[7], sample_word[6:0], 8'd0};
            FMT_F32: dec = f_val;
            default: dec = {sample_word[15], sample_word[15:0]};
        endcase
    end

    assign dec_ext = {{(SUM_W - VALUE_W){dec[VALUE_W-1]}}, dec};

    // Accumulate the frame
    assign accept       = sample_valid && !q_full;
    assign sample_stall = q_full;
    assign pos_inc      = pos_reg + 4'd1;
    assign frame_done   = pos_inc >= chans;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (chans == 4'd1)
        begin
            left_next  = dec_ext;
            right_next = dec_ext;
        end
        else if (!pos_reg[0])
        begin
            left_next = left_reg + dec_ext;
        end
        else
        begin
            right_next = right_reg + dec_ext;
        end
        pos_next = pos_inc;
    end

    // Hand finished frames and block ends to the queue
    assign q_push            = accept && (frame_done || last_in_block);
    assign q_ctl.frame_done  = frame_done;
    assign q_ctl.last_in_block = last_in_block;
    assign q_ctl.mono        = (cfg.output_channels == OUT_MONO);
    assign q_ctl.chans       = chans;
    assign q_left            = left_next;
    assign q_right           = right_next;

    // Advance or clear the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (accept)
        begin
            if (frame_done || last_in_block)
            begin
                pos_reg   <= '0;
                left_reg  <= '0;
                right_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                left_reg  <= left_next;
                right_reg <= right_next;
            end
        end
    end

endmodule

@@ rtl/core/pdm_queue.sv @@
`timescale 1ns / 1ps

module pdm_queue #(
    parameter int WIDTH = pdm_pkg::REC_CTL_W,
    parameter int DEPTH = pdm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import pdm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/pdm_div.sv @@
`timescale 1ns / 1ps

module pdm_div #(
    parameter int DIV_W = 47,
    parameter int DVS_W = 15,
    parameter int TOP_W = $clog2(DIV_W)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  logic [TOP_W-1:0] top_bit,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);
    import pdm_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [TOP_W-1:0] bit_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // One restoring step per cycle, most significant bit first
    assign trial = {rem_reg, dvd_reg[bit_reg]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= top_bit;
            end
            else if (busy_reg)
            begin
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - TOP_W'(1);
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg          <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg[bit_reg] <= fits;
        end
    end

endmodule

@@ rtl/core/pdm_back.sv @@
`timescale 1ns / 1ps

module pdm_back #(
    parameter int MAX_BLOCK_FRAMES = pdm_pkg::MAX_BLOCK_FRAMES_DEF,
    parameter int SUM_W            = pdm_pkg::sum_width(pdm_pkg::MAX_INPUT_CHANNELS_DEF)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    output logic                                q_pop,
    input  pdm_pkg::rec_ctl_t                   q_ctl,
    input  logic signed [SUM_W-1:0]             q_left,
    input  logic signed [SUM_W-1:0]             q_right,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pdm_pkg::VALUE_W-1:0]  left_value,
    output logic signed [pdm_pkg::VALUE_W-1:0]  right_value,
    output logic                                level_valid,
    output logic [pdm_pkg::LEVEL_W-1:0]         smoothed_level
);
    import pdm_pkg::*;

    localparam int CAP      = block_cap(MAX_BLOCK_FRAMES);
    localparam int COUNT_W  = count_width(MAX_BLOCK_FRAMES);
    localparam int ENERGY_W = energy_width(MAX_BLOCK_FRAMES);
    localparam int DVS_W    = (COUNT_W > 5) ? COUNT_W : 5;
    localparam int DIV_W    = (ENERGY_W > SUM_W + 2) ? ENERGY_W : SUM_W + 2;
    localparam int TOP_W    = $clog2(DIV_W);

    localparam logic [COUNT_W-1:0]      CAP_V  = COUNT_W'(CAP);
    localparam logic signed [SUM_W:0]   V_MAX  = (SUM_W + 1)'(Q_MAX_I);
    localparam logic signed [SUM_W:0]   V_MIN  = (SUM_W + 1)'(Q_MIN_I);
    localparam logic [TOP_W-1:0]        TOP_SCALE  = TOP_W'(SUM_W + 1);
    localparam logic [TOP_W-1:0]        TOP_ENERGY = TOP_W'(ENERGY_W - 1);

    back_state_t               state_reg, state_next;
    rec_ctl_t                  ctl_reg;
    logic signed [SUM_W-1:0]   l_reg;
    logic signed [SUM_W-1:0]   r_reg;
    logic signed [VALUE_W-1:0] lo_reg;
    logic signed [VALUE_W-1:0] ro_reg;
    logic [32:0]               sq_reg;
    logic [ENERGY_W-1:0]       energy_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [MEAN_W-1:0]         mean_reg;
    logic [LEVEL_W-1:0]        level_reg;
    logic                      upd_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_left_reg;
    logic signed [VALUE_W-1:0] out_right_reg;
    logic                      out_upd_reg;
    logic [LEVEL_W-1:0]        out_level_reg;

    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic [TOP_W-1:0]          div_top;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quo;

    logic [SUM_W-1:0]          l_mag;
    logic [SUM_W-1:0]          r_mag;
    logic [SUM_W+1:0]          l_dvd;
    logic [SUM_W+1:0]          r_dvd;
    logic signed [SUM_W-1:0]   quo_s;
    logic signed [SUM_W:0]     l_ext;
    logic signed [SUM_W:0]     r_ext;
    logic signed [SUM_W:0]     mix;
    logic [SUM_W:0]            mix_mag;
    logic [SUM_W:0]            half_mag;
    logic signed [SUM_W:0]     halved;
    logic signed [33:0]        sq_a;
    logic signed [33:0]        sq_b;
    logic [38:0]               lvl_sum;
    logic [36:0]               lvl_new;
    logic                      can_count;
    logic                      out_free;

    function automatic logic signed [VALUE_W-1:0] sat_v(input logic signed [SUM_W:0] v);
        if (v > V_MAX)
        begin
            return VALUE_W'(Q_MAX_I);
        end
        else if (v < V_MIN)
        begin
            return VALUE_W'(Q_MIN_I);
        end
        return v[VALUE_W-1:0];
    endfunction

    // Shared divider for channel scaling and the block mean
    pdm_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W),
        .TOP_W (TOP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .top_bit  (div_top),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Datapath terms
    assign l_mag    = l_reg[SUM_W-1] ? SUM_W'(-l_reg) : SUM_W'(l_reg);
    assign r_mag    = r_reg[SUM_W-1] ? SUM_W'(-r_reg) : SUM_W'(r_reg);
    assign l_dvd    = {l_mag, 2'b00} + (SUM_W + 2)'(ctl_reg.chans);
    assign r_dvd    = {r_mag, 2'b00} + (SUM_W + 2)'(ctl_reg.chans);
    assign quo_s    = div_quo[SUM_W-1:0];
    assign l_ext    = {l_reg[SUM_W-1], l_reg};
    assign r_ext    = {r_reg[SUM_W-1], r_reg};
    assign mix      = l_ext + r_ext;
    assign mix_mag  = mix[SUM_W] ? (SUM_W + 1)'(-mix) : (SUM_W + 1)'(mix);
    assign half_mag = (mix_mag + (SUM_W + 1)'(1)) >> 1;
    assign halved   = mix[SUM_W] ? -signed'(half_mag) : signed'(half_mag);
    assign sq_a     = lo_reg * lo_reg;
    assign sq_b     = ro_reg * ro_reg;
    assign lvl_sum  = {2'b00, level_reg, 1'b0} + {3'b000, level_reg}
                    + {6'd0, mean_reg};
    assign lvl_new  = lvl_sum[38:2];
    assign can_count = count_reg < CAP_V;
    assign out_free = !out_valid_reg || !result_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!q_ctl.frame_done)
                    begin
                        state_next = BK_END;
                    end
                    else if (q_ctl.chans > 4'd2)
                    begin
                        state_next = BK_DIV_L;
                    end
                    else
                    begin
                        state_next = BK_FORM;
                    end
                end
            end
            BK_DIV_L:  state_next = BK_WAIT_L;
            BK_WAIT_L: state_next = div_done ? BK_DIV_R : BK_WAIT_L;
            BK_DIV_R:  state_next = BK_WAIT_R;
            BK_WAIT_R: state_next = div_done ? BK_FORM : BK_WAIT_R;
            BK_FORM:   state_next = BK_SQ_A;
            BK_SQ_A:   state_next = BK_ACC_A;
            BK_ACC_A:  state_next = ctl_reg.mono ? BK_END : BK_SQ_B;
            BK_SQ_B:   state_next = BK_ACC_B;
            BK_ACC_B:  state_next = BK_END;
            BK_END:
            begin
                if (!ctl_reg.last_in_block)
                begin
                    state_next = BK_EMIT;
                end
                else if (count_reg != '0)
                begin
                    state_next = BK_DIV_E;
                end
                else if (ctl_reg.frame_done)
                begin
                    state_next = BK_EMIT;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV_E:  state_next = BK_WAIT_E;
            BK_WAIT_E: state_next = div_done ? BK_LEVEL : BK_WAIT_E;
            BK_LEVEL:  state_next = BK_EMIT;
            BK_EMIT:   state_next = out_free ? BK_IDLE : BK_EMIT;
            default:   state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(l_dvd);
        div_divisor  = DVS_W'({ctl_reg.chans, 1'b0});
        div_top      = TOP_SCALE;
        case (state_reg)
            BK_IDLE:  q_pop = !q_empty;
            BK_DIV_L: div_start = 1'b1;
            BK_DIV_R:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_dvd);
            end
            BK_DIV_E:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(energy_reg);
                div_divisor  = DVS_W'(count_reg);
                div_top      = TOP_ENERGY;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Block energy, count and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            count_reg  <= '0;
            level_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                BK_ACC_A, BK_ACC_B:
                begin
                    if (can_count)
                    begin
                        energy_reg <= energy_reg + ENERGY_W'(sq_reg);
                        count_reg  <= count_reg + COUNT_W'(1);
                    end
                end
                BK_LEVEL:
                begin
                    level_reg  <= lvl_new[36] ? '1 : lvl_new[LEVEL_W-1:0];
                    energy_reg <= '0;
                    count_reg  <= '0;
                end
                default:
                begin
                    energy_reg <= energy_reg;
                end
            endcase
        end
    end

    // Working values of the current record
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    ctl_reg <= q_ctl;
                    l_reg   <= q_left;
                    r_reg   <= q_right;
                    lo_reg  <= '0;
                    ro_reg  <= '0;
                    upd_reg <= 1'b0;
                end
            end
            BK_WAIT_L:
            begin
                if (div_done)
                begin
                    l_reg <= l_reg[SUM_W-1] ? -quo_s : quo_s;
                end
            end
            BK_WAIT_R:
            begin
                if (div_done)
                begin
                    r_reg <= r_reg[SUM_W-1] ? -quo_s : quo_s;
                end
            end
            BK_FORM:
            begin
                if (ctl_reg.mono)
                begin
                    lo_reg <= (ctl_reg.chans == 4'd1) ? sat_v(l_ext) : sat_v(halved);
                    ro_reg <= '0;
                end
                else
                begin
                    lo_reg <= sat_v(l_ext);
                    ro_reg <= sat_v(r_ext);
                end
            end
            BK_SQ_A:   sq_reg <= sq_a[32:0];
            BK_SQ_B:   sq_reg <= sq_b[32:0];
            BK_WAIT_E:
            begin
                if (div_done)
                begin
                    mean_reg <= div_quo[MEAN_W-1:0];
                end
            end
            BK_LEVEL:  upd_reg <= 1'b1;
            default:
            begin
                upd_reg <= upd_reg;
            end
        endcase
    end

    // Output register: load a finished result, drop it when transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_upd_reg   <= 1'b0;
            out_level_reg <= '0;
        end
        else if (state_reg == BK_EMIT && out_free)
        begin
            out_valid_reg <= 1'b1;
            out_upd_reg   <= upd_reg;
            out_level_reg <= level_reg;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_EMIT && out_free)
        begin
            out_left_reg  <= lo_reg;
            out_right_reg <= ro_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign left_value     = out_left_reg;
    assign right_value    = out_right_reg;
    assign level_valid    = out_upd_reg;
    assign smoothed_level = out_level_reg;

endmodule

@@ rtl/core/pcm_downmix_level_meter.sv @@
`timescale 1ns / 1ps

// Front end takes one sample per cycle while the record queue has room.
// Back end handles one record at a time: it scales both sums on the shared divider
// when more than two channels are summed, then forms, squares and accumulates the
// output values (the left one only for mono); a block end adds a division of energy
// by count and a level update, skipped when nothing was counted. The back sequencer
// and its shared bit-serial divider set the sustained rate.
// Asynchronous active-low reset clears frame sums, energy, count and level, and loads
// the default configuration.
module pcm_downmix_level_meter #(
    parameter int MAX_INPUT_CHANNELS = pdm_pkg::MAX_INPUT_CHANNELS_DEF,
    parameter int MAX_BLOCK_FRAMES   = pdm_pkg::MAX_BLOCK_FRAMES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pdm_pkg::PADDR_W-1:0]         paddr,
    input  logic [pdm_pkg::PDATA_W-1:0]         pwdata,
    output logic [pdm_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic [pdm_pkg::SAMPLE_W-1:0]        sample_word,
    input  logic                                last_in_block,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    output logic signed [pdm_pkg::VALUE_W-1:0]  left_value,
    output logic signed [pdm_pkg::VALUE_W-1:0]  right_value,
    output logic                                level_valid,
    output logic [pdm_pkg::LEVEL_W-1:0]         smoothed_level,
    output logic                                result_valid,
    input  logic                                result_stall
);
    import pdm_pkg::*;

    localparam int SUM_W = sum_width(MAX_INPUT_CHANNELS);
    localparam int REC_W = REC_CTL_W + 2 * SUM_W;

    cfg_t                    cfg_reg;
    logic                    cfg_write;
    logic [1:0]              cfg_index;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    rec_ctl_t                push_ctl;
    logic signed [SUM_W-1:0] push_left;
    logic signed [SUM_W-1:0] push_right;
    logic [REC_W-1:0]        push_rec;
    logic [REC_W-1:0]        pop_rec;
    rec_ctl_t                pop_ctl;
    logic signed [SUM_W-1:0] pop_left;
    logic signed [SUM_W-1:0] pop_right;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format   <= FMT_S16;
            cfg_reg.input_channels  <= INPUT_CH_RESET;
            cfg_reg.output_channels <= OUT_STEREO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FORMAT:    cfg_reg.sample_format   <= pwdata[1:0];
                REG_INPUT_CH:  cfg_reg.input_channels  <= pwdata[3:0];
                REG_OUTPUT_CH: cfg_reg.output_channels <= pwdata[1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_FORMAT:    prdata = PDATA_W'(cfg_reg.sample_format);
            REG_INPUT_CH:  prdata = PDATA_W'(cfg_reg.input_channels);
            REG_OUTPUT_CH: prdata = PDATA_W'(cfg_reg.output_channels);
            default:       prdata = '0;
        endcase
    end

    // Decode and frame accumulation
    pdm_front #(
        .MAX_INPUT_CHANNELS (MAX_INPUT_CHANNELS),
        .SUM_W              (SUM_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .sample_word   (sample_word),
        .last_in_block (last_in_block),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_ctl         (push_ctl),
        .q_left        (push_left),
        .q_right       (push_right)
    );

    // Frame records between front and back
    assign push_rec = {push_ctl, push_left, push_right};

    pdm_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_rec),
        .pop       (q_pop),
        .pop_data  (pop_rec),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign pop_ctl   = pop_rec[REC_W-1 -: REC_CTL_W];
    assign pop_left  = pop_rec[2*SUM_W-1 -: SUM_W];
    assign pop_right = pop_rec[SUM_W-1:0];

    // Scaling, energy and level sequencer
    pdm_back #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
        .SUM_W            (SUM_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_ctl          (pop_ctl),
        .q_left         (pop_left),
        .q_right        (pop_right),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .left_value     (left_value),
        .right_value    (right_value),
        .level_valid    (level_valid),
        .smoothed_level (smoothed_level)
    );

    // Queue never reports full and empty together
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("record queue full and empty at once");

    // A record enters the queue only with an accepted sample
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (sample_valid && !sample_stall))
        else $error("queue push without a sample transfer");

    // A result without a level update repeats the level last shown
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !level_valid) |-> (smoothed_level == $past(smoothed_level)))
        else $error("level changed on a result without update");

endmodule
